/* sv/lmss_pkg.sv */
// ----------------------------------------------------------------------------
// lmss_pkg: shared types and constants for the LED matrix scan shifter
// Frame geometry, shift run lengths and the request structs between modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lmss_pkg;

  localparam int COLUMNS     = 11;
  localparam int ROW_BITS    = 8;
  localparam int SELECT_BITS = 16;
  localparam int RUN_BITS    = SELECT_BITS + ROW_BITS;

  localparam int COL_W = 4;
  localparam int ROW_W = 3;
  localparam int CNT_W = 5;

  // Operation codes carried on the input tuser
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_SCAN  = 1'b1
  } op_t;

  // Chain codes carried on the output tuser
  typedef enum logic {
    CHAIN_SELECT = 1'b0,
    CHAIN_ROWS   = 1'b1
  } chain_t;

  // Pixel write request into the frame store
  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             on;
  } pix_wr_t;

  // Load request into the serializer
  typedef struct packed {
    logic                   en;
    logic [SELECT_BITS-1:0] select;
    logic [ROW_BITS-1:0]    rows;
  } ser_load_t;

endpackage

/* sv/lmss_frame_store.sv */
// ----------------------------------------------------------------------------
// lmss_frame_store: pixel frame store
// One row byte per column; single pixel set/clear, one read port by column.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lmss_frame_store (
  input  logic                            clk,
  input  logic                            rst,
  input  lmss_pkg::pix_wr_t               wr,
  input  logic [lmss_pkg::COL_W-1:0]      rd_col,
  output logic [lmss_pkg::ROW_BITS-1:0]   rd_data
);
  import lmss_pkg::*;

  logic [ROW_BITS-1:0] frame [COLUMNS];

  // Set or clear one pixel; drop writes to columns beyond the matrix
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COLUMNS; i++) begin
        frame[i] <= '0;
      end
    end else if (wr.en && (32'(wr.col) < COLUMNS)) begin
      frame[wr.col][wr.row] <= wr.on;
    end
  end

  // Read the scan column's row byte; out-of-range reads fall back to column 0
  always_comb begin
    if (32'(rd_col) < COLUMNS) begin
      rd_data = frame[rd_col];
    end else begin
      rd_data = frame[0];
    end
  end

endmodule

/* sv/lmss_serializer.sv */
// ----------------------------------------------------------------------------
// lmss_serializer: bit-serial output of one scan run
// Shifts the select word then the row byte out MSB first, one bit per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lmss_serializer (
  input  logic                  clk,
  input  logic                  rst,
  input  lmss_pkg::ser_load_t   load,
  output logic                  busy,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // [0] data_bit, [1] latch_after, [7:2] zero
  output logic                  m_tuser,   // [0] chain
  output logic                  m_tlast
);
  import lmss_pkg::*;

  localparam logic [CNT_W-1:0] SEL_LAST = CNT_W'(SELECT_BITS - 1);
  localparam logic [CNT_W-1:0] RUN_LAST = CNT_W'(RUN_BITS - 1);

  logic [RUN_BITS-1:0] shreg;
  logic [CNT_W-1:0]    cnt;
  logic                beat;

  assign beat = busy && m_tready;

  // Load a run, advance one bit per taken beat, clear busy after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load.en) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (beat) begin
      if (cnt == RUN_LAST) begin
        busy <= 1'b0;
        cnt  <= '0;
      end else begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  // Shift line holds the bits still to go, next bit at the top
  always_ff @(posedge clk) begin
    if (load.en) begin
      shreg <= {load.select, load.rows};
    end else if (beat) begin
      shreg <= {shreg[RUN_BITS-2:0], 1'b0};
    end
  end

  // Decorate the current bit with chain and latch flags
  always_comb begin
    m_tvalid   = busy;
    m_tdata    = '0;
    m_tdata[0] = shreg[RUN_BITS-1];
    m_tdata[1] = (cnt == SEL_LAST) || (cnt == RUN_LAST);
    m_tuser    = (cnt > SEL_LAST) ? CHAIN_ROWS : CHAIN_SELECT;
    m_tlast    = (cnt == RUN_LAST);
  end

  // A new run only starts when the previous one is done
  assert property (@(posedge clk) disable iff (rst) load.en |-> !busy)
    else $error("run loaded while busy");
  assert property (@(posedge clk) disable iff (rst) load.en |=> busy && cnt == '0)
    else $error("run did not start at bit zero");
  assert property (@(posedge clk) disable iff (rst) busy && !m_tready |=> $stable(cnt))
    else $error("bit counter moved on a stall");
  assert property (@(posedge clk) disable iff (rst) beat && m_tlast |=> !busy)
    else $error("busy held after the final bit");

endmodule

/* sv/led_matrix_scan_shifter.sv */
// ----------------------------------------------------------------------------
// led_matrix_scan_shifter: multiplexed LED matrix scan for 74HC595 chains
// Pixel writes update the frame store; scan ticks emit a 24-bit shift run.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata                                  tuser      tlast
// s_*       in   [3:0] column [6:4] row [7] pixel_on    operation  -
// m_*       out  [0] data_bit [1] latch_after           chain      last
//
// A write request is applied to the frame store when taken. A scan tick loads
// a 24-bit shift line that then delivers 24 result beats, one per cycle while
// the output is ready; the input is not ready until the last beat is taken.
// Output stalls hold the current bit and counter. Reset (rst, synchronous)
// clears the frame store, the scan column and the serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_matrix_scan_shifter (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [3:0] column, [6:4] row, [7] pixel_on
  input  logic       s_tuser,   // [0] operation
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [0] data_bit, [1] latch_after, [7:2] zero
  output logic       m_tuser,   // [0] chain
  output logic       m_tlast
);
  import lmss_pkg::*;

  logic                s_take;
  logic                busy;
  logic [COL_W-1:0]    scan_col;
  logic [COL_W-1:0]    scan_col_next;
  logic [ROW_BITS-1:0] rows;
  pix_wr_t             wr;
  ser_load_t           load;

  assign s_tready = !busy;
  assign s_take   = s_tvalid && s_tready;

  // Decode the request into a pixel write or a scan load
  always_comb begin
    wr.en   = s_take && (s_tuser == OP_WRITE);
    wr.col  = s_tdata[3:0];
    wr.row  = s_tdata[6:4];
    wr.on   = s_tdata[7];
    load.en = s_take && (s_tuser == OP_SCAN);
    load.select = '0;
    load.select[scan_col] = 1'b1;
    load.rows   = rows;
  end

  // Advance the scan column after each tick, wrapping at the matrix width
  always_comb begin
    if (32'(scan_col) >= COLUMNS - 1) begin
      scan_col_next = '0;
    end else begin
      scan_col_next = scan_col + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_col <= '0;
    end else if (load.en) begin
      scan_col <= scan_col_next;
    end
  end

  lmss_frame_store u_frame (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_col  (scan_col),
    .rd_data (rows)
  );

  lmss_serializer u_ser (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .busy     (busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Scan column stays inside the matrix and only moves on a scan tick
  assert property (@(posedge clk) disable iff (rst) 32'(scan_col) < COLUMNS)
    else $error("scan column out of range");
  assert property (@(posedge clk) disable iff (rst) !load.en |=> $stable(scan_col))
    else $error("scan column moved without a scan tick");
  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !s_tready)
    else $error("input ready during a scan run");

endmodule
